>>> sv/ptad_pkg.sv
// ----------------------------------------------------------------------------
// ptad_pkg
// Types and fixed widths shared by the polyline tip-at-distance unit.
// ----------------------------------------------------------------------------
package ptad_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DistW    = 24;
  localparam int unsigned MagW     = 33;   // |difference| of two coordinates
  localparam int unsigned SqW      = 66;   // squared length, bit 65 always zero
  localparam int unsigned SremW    = 36;   // square-root partial remainder
  localparam int unsigned NumW     = 57;   // rem * |d|
  localparam int unsigned DremW    = 34;   // divider partial remainder
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned DivSteps  = 57;

  typedef enum logic [1:0] {
    ST_INTERP  = 2'd0,
    ST_RAN_OFF = 2'd1,
    ST_SHORT   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    M_END_A = 2'd0,   // front end against the junction
    M_END_B = 2'd1,   // back end against the junction
    M_SEG   = 2'd2    // segment end against segment start
  } mode_e;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_RD     = 12'b0000_0000_0010,
    S_LD     = 12'b0000_0000_0100,
    S_DIFF   = 12'b0000_0000_1000,
    S_SQX    = 12'b0000_0001_0000,
    S_SQY    = 12'b0000_0010_0000,
    S_SQRT   = 12'b0000_0100_0000,
    S_CHECK  = 12'b0000_1000_0000,
    S_IMUL   = 12'b0001_0000_0000,
    S_IDIV   = 12'b0010_0000_0000,
    S_IAPPLY = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

endpackage

>>> sv/polyline_tip_at_distance_unit.sv
// ----------------------------------------------------------------------------
// polyline_tip_at_distance_unit
// Walks a stored polyline from the end nearer the junction and returns the
// point that lies the configured distance along it, or its far end if short.
// ----------------------------------------------------------------------------
// Usage: points arrive one item each on the s_axis channel; tlast marks the
// final point of a line, and the junction is taken from the first item of the
// line. Only the final item gives a result, one item on m_axis. target
// distance is written through cfg_we_i / cfg_wdata_i while the unit is idle:
// a rule for the user, as the unit does not enforce it. Throughput: an item
// that is not last is taken while the unit is idle and leaves it idle, so
// the next one can follow in the next cycle. A final item holds the input
// off for the whole walk: comparing the two ends, each segment walked (two
// memory reads, difference, two squaring passes on the shared multiplier,
// then the square root at one bit per cycle) and the interpolation (restoring
// divider, once per coordinate). Fewer than two points answer with ST_SHORT.
// The result waits in an output register; a stalled receiver holds the unit
// only when a new result is ready and the register is still full.
// Reset empties the point store count and the overflow flag and sets the
// target distance to 1000; store contents are not cleared.
// ----------------------------------------------------------------------------
module polyline_tip_at_distance_unit #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [23:0]  cfg_wdata_i,    // target_distance
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x[31:0], point_y[63:32], junction_x[95:64], junction_y[127:96]
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // is_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tip_x[31:0], tip_y[63:32], status[65:64], zero fill[71:66]
  output logic [71:0]  m_axis_tdata
);
  import ptad_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  state_e state_q;
  mode_e  mode_q;

  logic [CW-1:0] count_q;
  logic          ovf_q;
  logic [DistW-1:0] target_q;
  logic signed [CoordW-1:0] jx_q, jy_q;

  logic [CoordW-1:0] x_mem [MAX_POINTS];
  logic [CoordW-1:0] y_mem [MAX_POINTS];
  logic [AW-1:0] ra0_q, ra1_q;
  logic [CoordW-1:0] rx0_q, ry0_q, rx1_q, ry1_q;

  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [MagW-1:0] dx_q, dy_q;
  logic sxn_q, syn_q;
  logic [SqW-1:0] sq_q;
  logic [SqW-2:0] fd_q;
  logic           front_q;
  logic [MagW-1:0]  root_q;
  logic [SremW-1:0] srem_q;
  logic [5:0]       iter_q;
  logic [DistW-1:0] acc_q, rem_q;
  logic [CW-1:0]    seg_q;
  logic [AW-1:0]    ib_q;
  logic [NumW-1:0]  num_q;
  logic [DremW-1:0] drem_q;
  logic             iy_q;
  logic [CoordW-1:0] tx_q, ty_q;
  status_e           st_q;
  logic [CoordW-1:0] ox_q, oy_q;
  logic [1:0]        ost_q;
  logic              ovalid_q;

  logic        in_acc;
  logic [CW-1:0] cnt_nxt;
  logic signed [CoordW-1:0] in_px, in_py, in_jx, in_jy;

  assign in_px = s_axis_tdata[31:0];
  assign in_py = s_axis_tdata[63:32];
  assign in_jx = s_axis_tdata[95:64];
  assign in_jy = s_axis_tdata[127:96];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cnt_nxt = (count_q < CW'(MAX_POINTS)) ? count_q + CW'(1) : count_q;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, ost_q, oy_q, ox_q};

  // Difference unit.
  logic signed [CoordW-1:0] du_x, du_y, dv_x, dv_y;
  logic signed [MagW-1:0]   dfx, dfy;
  always_comb begin
    du_x = bx_q; du_y = by_q; dv_x = ax_q; dv_y = ay_q;
    case (mode_q)
      M_END_A: begin du_x = ax_q; du_y = ay_q; dv_x = jx_q; dv_y = jy_q; end
      M_END_B: begin dv_x = jx_q; dv_y = jy_q; end
      default: ;
    endcase
    dfx = {du_x[CoordW-1], du_x} - {dv_x[CoordW-1], dv_x};
    dfy = {du_y[CoordW-1], du_y} - {dv_y[CoordW-1], dv_y};
  end

  // Shared multiplier.
  logic [MagW-1:0]   mul_a, mul_b;
  logic [2*MagW-1:0] prod;
  always_comb begin
    mul_a = dx_q;
    mul_b = dx_q;
    if (state_q == S_SQY) begin
      mul_a = dy_q; mul_b = dy_q;
    end else if (state_q == S_IMUL) begin
      mul_a = {{(MagW-DistW){1'b0}}, rem_q};
      mul_b = iy_q ? dy_q : dx_q;
    end
    prod = mul_a * mul_b;
  end

  // One square-root and one divider step, plus the length sums and tip update.
  logic [SremW-1:0] s_try, s_trial;
  logic [DremW-1:0] d_try;
  logic [SqW-2:0]   sq_sum;
  logic [MagW:0]    walk_sum;
  logic [CoordW-1:0] ap_base, ap_res;
  logic              ap_neg;
  always_comb begin
    s_try   = {srem_q[SremW-3:0], sq_q[SqW-1:SqW-2]};
    s_trial = {1'b0, root_q, 2'b01};
    d_try   = {drem_q[DremW-2:0], num_q[NumW-1]};
    sq_sum  = {1'b0, sq_q[63:0]} + {1'b0, prod[63:0]};
    walk_sum = {{(MagW+1-DistW){1'b0}}, acc_q} + {1'b0, root_q};
    ap_base = iy_q ? ay_q : ax_q;
    ap_neg  = iy_q ? syn_q : sxn_q;
    ap_res  = ap_neg ? ap_base - num_q[CoordW-1:0] : ap_base + num_q[CoordW-1:0];
  end

  // Point store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (in_acc && (count_q < CW'(MAX_POINTS))) begin
      x_mem[count_q[AW-1:0]] <= in_px;
      y_mem[count_q[AW-1:0]] <= in_py;
    end
    rx0_q <= x_mem[ra0_q];
    ry0_q <= y_mem[ra0_q];
    rx1_q <= x_mem[ra1_q];
    ry1_q <= y_mem[ra1_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      jx_q     <= '0;
      jy_q     <= '0;
      target_q <= DistW'(1000);
      ovalid_q <= 1'b0;
      mode_q   <= M_END_A;
    end else begin
      if (cfg_we_i) target_q <= cfg_wdata_i;
      // In S_DONE the output register is handled by the state itself.
      if (ovalid_q && m_axis_tready && (state_q != S_DONE)) ovalid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (count_q == '0) begin
              jx_q <= in_jx;
              jy_q <= in_jy;
            end
            count_q <= cnt_nxt;
            if (count_q == CW'(MAX_POINTS)) ovf_q <= 1'b1;
            if (s_axis_tlast) begin
              if (cnt_nxt < CW'(2)) begin
                tx_q    <= (count_q == '0) ? in_jx : jx_q;
                ty_q    <= (count_q == '0) ? in_jy : jy_q;
                st_q    <= ST_SHORT;
                state_q <= S_DONE;
              end else begin
                ra0_q   <= '0;
                ra1_q   <= AW'(cnt_nxt - CW'(1));
                mode_q  <= M_END_A;
                state_q <= S_RD;
              end
            end
          end
        end
        S_RD: state_q <= S_LD;
        S_LD: begin
          ax_q <= rx0_q; ay_q <= ry0_q;
          bx_q <= rx1_q; by_q <= ry1_q;
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          dx_q  <= dfx[MagW-1] ? MagW'(0) - dfx : dfx;
          dy_q  <= dfy[MagW-1] ? MagW'(0) - dfy : dfy;
          sxn_q <= dfx[MagW-1];
          syn_q <= dfy[MagW-1];
          state_q <= S_SQX;
        end
        S_SQX: begin
          sq_q    <= {2'b00, prod[63:0]};
          state_q <= S_SQY;
        end
        S_SQY: begin
          sq_q <= {1'b0, sq_sum};
          unique case (mode_q)
            M_END_A: begin
              fd_q    <= sq_sum;
              mode_q  <= M_END_B;
              state_q <= S_DIFF;
            end
            M_END_B: begin
              front_q <= (fd_q <= sq_sum);
              ib_q    <= (fd_q <= sq_sum) ? AW'(1) : AW'(count_q - CW'(2));
              ra0_q   <= (fd_q <= sq_sum) ? AW'(0) : AW'(count_q - CW'(1));
              ra1_q   <= (fd_q <= sq_sum) ? AW'(1) : AW'(count_q - CW'(2));
              tx_q    <= (fd_q <= sq_sum) ? bx_q : ax_q;
              ty_q    <= (fd_q <= sq_sum) ? by_q : ay_q;
              st_q    <= ST_RAN_OFF;
              acc_q   <= '0;
              seg_q   <= count_q - CW'(1);
              mode_q  <= M_SEG;
              state_q <= S_RD;
            end
            default: begin
              root_q  <= '0;
              srem_q  <= '0;
              iter_q  <= '0;
              state_q <= S_SQRT;
            end
          endcase
        end
        S_SQRT: begin
          sq_q <= {sq_q[SqW-3:0], 2'b00};
          if (s_try >= s_trial) begin
            srem_q <= s_try - s_trial;
            root_q <= {root_q[MagW-2:0], 1'b1};
          end else begin
            srem_q <= s_try;
            root_q <= {root_q[MagW-2:0], 1'b0};
          end
          iter_q <= iter_q + 6'd1;
          if (iter_q == 6'(SqrtSteps - 1)) state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (walk_sum >= {{(MagW+1-DistW){1'b0}}, target_q}) begin
            if (root_q == '0) begin
              tx_q    <= ax_q;
              ty_q    <= ay_q;
              st_q    <= ST_INTERP;
              state_q <= S_DONE;
            end else begin
              rem_q   <= target_q - acc_q;
              iy_q    <= 1'b0;
              state_q <= S_IMUL;
            end
          end else begin
            // The sum stays below the 24-bit target here.
            acc_q <= walk_sum[DistW-1:0];
            if (seg_q == CW'(1)) begin
              state_q <= S_DONE;
            end else begin
              seg_q   <= seg_q - CW'(1);
              ib_q    <= front_q ? ib_q + AW'(1) : ib_q - AW'(1);
              ra0_q   <= ib_q;
              ra1_q   <= front_q ? ib_q + AW'(1) : ib_q - AW'(1);
              state_q <= S_RD;
            end
          end
        end
        S_IMUL: begin
          num_q   <= prod[NumW-1:0];
          drem_q  <= '0;
          iter_q  <= '0;
          state_q <= S_IDIV;
        end
        S_IDIV: begin
          if (d_try >= {1'b0, root_q}) begin
            drem_q <= d_try - {1'b0, root_q};
            num_q  <= {num_q[NumW-2:0], 1'b1};
          end else begin
            drem_q <= d_try;
            num_q  <= {num_q[NumW-2:0], 1'b0};
          end
          iter_q <= iter_q + 6'd1;
          if (iter_q == 6'(DivSteps - 1)) state_q <= S_IAPPLY;
        end
        S_IAPPLY: begin
          if (iy_q) begin
            ty_q    <= ap_res;
            st_q    <= ST_INTERP;
            state_q <= S_DONE;
          end else begin
            tx_q    <= ap_res;
            iy_q    <= 1'b1;
            state_q <= S_IMUL;
          end
        end
        S_DONE: begin
          if (!ovalid_q || m_axis_tready) begin
            ox_q     <= tx_q;
            oy_q     <= ty_q;
            ost_q    <= (ovf_q && (st_q != ST_SHORT)) ? ST_OVERFLOW : st_q;
            ovalid_q <= 1'b1;
            count_q  <= '0;
            ovf_q    <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The store count never passes the store size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("point count beyond store size");

  // A dropped point only happens with a full store.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CW'(MAX_POINTS)))
    else $error("overflow flag without a full store");

  // A final item closes the input until its result is issued.
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input open right after a final item");

endmodule
